FILE: design/lcdrn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdrn_pkg: shared types and constants of the character LCD nibble driver
// Request codes, the front-to-back command word, bus constants and the
// setup command table.
// ----------------------------------------------------------------------------
package lcdrn_pkg;

  localparam int CharsPerLineDef = 16;
  localparam int CmdFifoDepth    = 2;

  localparam int InitByteCount = 9;
  localparam int InitNibbles   = 2 * InitByteCount;
  localparam int StepW         = $clog2(InitNibbles);

  localparam logic [7:0]  BlankChar    = 8'h10;
  localparam logic [7:0]  AddrLine1Cmd = 8'hC0;
  localparam logic [7:0]  AddrLine0Cmd = 8'h80;
  localparam logic [7:0]  ClearCmd     = 8'h01;
  localparam logic [13:0] WaitHigh     = 14'd1000;
  localparam logic [13:0] WaitLow      = 14'd2000;
  localparam logic [13:0] WaitFirst    = 14'd12000;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_INIT    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef struct packed {
    req_e       kind;
    logic [7:0] data;
    logic       wrap;
    logic       row;
  } cmd_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h03;
      4'd1:    b = 8'h03;
      4'd2:    b = 8'h03;
      4'd3:    b = 8'h02;
      4'd4:    b = 8'h28;
      4'd5:    b = 8'h08;
      4'd6:    b = 8'h01;
      4'd7:    b = 8'h06;
      4'd8:    b = 8'h0E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: design/char_lcd_refresh_nibble_driver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_refresh_nibble_driver: two-line character LCD driver, 4-bit bus
// Takes load, refresh, init and clear requests and produces the nibble
// transfers for the display, each with register select, wait and end mark.
// ----------------------------------------------------------------------------
// A request is taken in any cycle the input queue is not full; a load causes
// no transfers, a refresh two or four, a clear two and an init eighteen. The
// output side produces one nibble transfer per cycle while the receiver pops,
// so the sustained rate is set by the nibble sequencer. A taken request passes
// the command stage, the command queue and the output register before its
// first transfer appears. The text store is valid right after reset; no
// clearing pass is needed. A two-entry command queue separates intake from output.
// ----------------------------------------------------------------------------
module char_lcd_refresh_nibble_driver #(
  parameter int CharsPerLine = lcdrn_pkg::CharsPerLineDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic        row_i,
  input  wire logic [3:0]  column_i,
  input  wire logic [7:0]  char_code_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             reg_select_o,
  output logic [3:0]       nibble_o,
  output logic [13:0]      wait_us_o,
  output logic             last_o
);

  logic            fr_valid;
  lcdrn_pkg::cmd_t fr_cmd;
  logic            q_full;
  lcdrn_pkg::cmd_t q_cmd;
  logic            q_empty;
  logic            q_pop;

  lcdrn_front #(
    .CharsPerLine(CharsPerLine)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .char_code_i (char_code_i),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (!q_full)
  );

  lcdrn_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .wdata_i (fr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_cmd),
    .empty_o (q_empty)
  );

  lcdrn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .empty        (empty),
    .pop          (pop),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

FILE: design/lcdrn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdrn_front: request intake, text store and refresh cursor
// Writes load requests into the text store, reads the cell under the cursor
// for refresh requests and hands refresh, init and clear commands onward.
// ----------------------------------------------------------------------------
module lcdrn_front #(
  parameter int CharsPerLine = lcdrn_pkg::CharsPerLineDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [1:0]      req_type_i,
  input  wire logic            row_i,
  input  wire logic [3:0]      column_i,
  input  wire logic [7:0]      char_code_i,
  output logic                 cmd_valid_o,
  output lcdrn_pkg::cmd_t      cmd_o,
  input  wire logic            cmd_ready_i
);

  localparam int ColW  = $clog2(CharsPerLine);
  localparam int AddrW = ColW + 1;
  localparam int Depth = 2 * (2 ** ColW);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [ColW-1:0]  col_q;
  logic             row_q;

  logic             s1_valid_q;
  lcdrn_pkg::req_e  s1_kind_q;
  logic             s1_wrap_q;
  logic             s1_row_q;
  logic [7:0]       rd_q;
  logic             rd_vld_q;

  lcdrn_pkg::req_e  req;
  logic             accept;
  logic             ld_hit;
  logic             rf_acc;
  logic             wrap;
  logic             s1_adv;
  logic [AddrW-1:0] ld_addr;
  logic [AddrW-1:0] rd_addr;

  assign req     = lcdrn_pkg::req_e'(req_type_i);
  assign s1_adv  = !s1_valid_q || cmd_ready_i;
  assign full    = !s1_adv;
  assign accept  = push && !full;
  assign ld_hit  = accept && (req == lcdrn_pkg::REQ_LOAD)
                   && (32'(column_i) < 32'(CharsPerLine));
  assign rf_acc  = accept && (req == lcdrn_pkg::REQ_REFRESH);
  assign wrap    = (col_q == ColW'(CharsPerLine - 1));
  assign ld_addr = {row_i, ColW'(column_i)};
  assign rd_addr = {row_q, col_q};

  always_ff @(posedge clk_i) begin
    if (ld_hit) begin
      mem_q[ld_addr] <= char_code_i;
    end
    if (rf_acc) begin
      rd_q <= mem_q[rd_addr];
    end
    if (s1_adv) begin
      s1_kind_q <= req;
      s1_wrap_q <= wrap;
      s1_row_q  <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      col_q      <= '0;
      row_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (ld_hit) begin
        vld_q[ld_addr] <= 1'b1;
      end
      if (rf_acc) begin
        rd_vld_q <= vld_q[rd_addr];
        if (wrap) begin
          col_q <= '0;
          row_q <= !row_q;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (s1_adv) begin
        s1_valid_q <= accept && (req != lcdrn_pkg::REQ_LOAD);
      end
    end
  end

  // blank a cell that was never written or holds zero
  assign cmd_valid_o  = s1_valid_q;
  assign cmd_o.kind   = s1_kind_q;
  assign cmd_o.data   = (rd_vld_q && (rd_q != 8'h00)) ? rd_q : lcdrn_pkg::BlankChar;
  assign cmd_o.wrap   = s1_wrap_q;
  assign cmd_o.row    = s1_row_q;

  a_refresh_reaches_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_acc |=> s1_valid_q)
    else $error("refresh transfer did not reach the command stage");

  a_cursor_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(CharsPerLine))
    else $error("refresh cursor past end of line");

endmodule
`default_nettype wire

FILE: design/lcdrn_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdrn_cmd_fifo: command queue between front and back
// Small register queue that decouples request intake from nibble output.
// ----------------------------------------------------------------------------
module lcdrn_cmd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  lcdrn_pkg::cmd_t       wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output lcdrn_pkg::cmd_t       rdata_o,
  output logic                  empty_o
);

  localparam int Depth = lcdrn_pkg::CmdFifoDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lcdrn_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("command queue count overflow");

endmodule
`default_nettype wire

FILE: design/lcdrn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdrn_back: nibble sequencer and result register
// Expands each queued command into its high and low nibbles with register
// select, wait time and end marker, one nibble per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module lcdrn_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  lcdrn_pkg::cmd_t         cmd_i,
  input  wire logic               cmd_empty_i,
  output logic                    cmd_pop_o,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    reg_select_o,
  output logic [3:0]              nibble_o,
  output logic [13:0]             wait_us_o,
  output logic                    last_o
);

  localparam int StepW = lcdrn_pkg::StepW;

  logic [StepW-1:0] step_q;
  logic             out_vld_q;
  logic             rs_q;
  logic [3:0]       nib_q;
  logic [13:0]      wait_q;
  logic             last_q;

  logic [3:0]       byte_idx;
  logic             high;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic [StepW-1:0] last_step;
  logic [13:0]      cur_wait;
  logic             is_last;
  logic             adv;
  logic             go;

  assign byte_idx = 4'(step_q >> 1);
  assign high     = !step_q[0];

  always_comb begin
    unique case (cmd_i.kind)
      lcdrn_pkg::REQ_REFRESH: begin
        cur_rs    = (byte_idx == 4'd0);
        cur_byte  = (byte_idx == 4'd0) ? cmd_i.data :
                    (cmd_i.row ? lcdrn_pkg::AddrLine0Cmd : lcdrn_pkg::AddrLine1Cmd);
        last_step = cmd_i.wrap ? StepW'(3) : StepW'(1);
      end
      lcdrn_pkg::REQ_INIT: begin
        cur_rs    = 1'b0;
        cur_byte  = lcdrn_pkg::init_byte(byte_idx);
        last_step = StepW'(lcdrn_pkg::InitNibbles - 1);
      end
      default: begin
        cur_rs    = 1'b0;
        cur_byte  = lcdrn_pkg::ClearCmd;
        last_step = StepW'(1);
      end
    endcase
  end

  assign cur_wait = high ? lcdrn_pkg::WaitHigh :
                    ((cmd_i.kind == lcdrn_pkg::REQ_INIT) && (byte_idx == 4'd0)) ?
                    lcdrn_pkg::WaitFirst : lcdrn_pkg::WaitLow;
  assign is_last  = (step_q == last_step);
  assign adv      = !out_vld_q || pop;
  assign go       = adv && !cmd_empty_i;
  assign cmd_pop_o = go && is_last;

  always_ff @(posedge clk_i) begin
    if (go) begin
      rs_q   <= cur_rs;
      nib_q  <= high ? cur_byte[7:4] : cur_byte[3:0];
      wait_q <= cur_wait;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= !cmd_empty_i;
      end
      if (go) begin
        step_q <= is_last ? '0 : step_q + 1'b1;
      end
    end
  end

  assign empty        = !out_vld_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < StepW'(lcdrn_pkg::InitNibbles))
    else $error("nibble step past end of init sequence");

  a_step_needs_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> !cmd_empty_i)
    else $error("command left the queue before its last nibble");

endmodule
`default_nettype wire

FILE: tb/sv/char_lcd_refresh_nibble_driver_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_refresh_nibble_driver_tb: self-checking bench of the LCD driver
// Walks a table of load, refresh, init and clear requests and then a long
// random mix. A behavioral copy of the text store and the refresh cursor
// predicts every nibble transfer, which is checked field by field against
// the output queue while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module char_lcd_refresh_nibble_driver_tb;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [13:0] wait_us;
    logic        last;
  } xfer_t;

  typedef struct packed {
    lcdrn_pkg::req_e kind;
    logic            row;
    logic [3:0]      col;
    logic [7:0]      chr;
    logic            typed;
    logic            t_rs;
    logic [7:0]      t_byte;
  } lcd_req_t;

  localparam int DirCount = 23;
  localparam int RandPerPhase = 116;
  localparam int HoldCycles = 300;

  localparam logic [7:0] SetupSeq [lcdrn_pkg::InitByteCount] = '{
    8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0E
  };

  localparam lcd_req_t DirTab [DirCount] = '{
    '{lcdrn_pkg::REQ_REFRESH, 1'b1, 4'd15, 8'hFF, 1'b1, 1'b1, lcdrn_pkg::BlankChar},
    '{lcdrn_pkg::REQ_CLEAR,   1'b1, 4'd15, 8'hFF, 1'b1, 1'b0, lcdrn_pkg::ClearCmd},
    '{lcdrn_pkg::REQ_INIT,    1'b1, 4'd9,  8'hC3, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_LOAD,    1'b0, 4'd1,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_LOAD,    1'b1, 4'd15, 8'hA5, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_LOAD,    1'b0, 4'd15, 8'h5A, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_LOAD,    1'b0, 4'd2,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_LOAD,    1'b1, 4'd0,  8'h01, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b1, 1'b1, 8'hFF},
    '{lcdrn_pkg::REQ_REFRESH, 1'b1, 4'd5,  8'h77, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b1, 4'd15, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{lcdrn_pkg::REQ_REFRESH, 1'b1, 4'd8,  8'h3C, 1'b0, 1'b0, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type_i = 2'd0;
  logic        row_i = 1'b0;
  logic [3:0]  column_i = 4'd0;
  logic [7:0]  char_code_i = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic        reg_select_o;
  logic [3:0]  nibble_o;
  logic [13:0] wait_us_o;
  logic        last_o;

  logic [7:0]  text_mem [2][lcdrn_pkg::CharsPerLineDef];
  logic        cur_row;
  logic [3:0]  cur_col;
  xfer_t       xfer_q [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_start = 1'b0;
  int          hold_left = 0;

  char_lcd_refresh_nibble_driver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .char_code_i  (char_code_i),
    .empty        (empty),
    .pop          (pop),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #(20 * 400000);
    $display("FAIL char_lcd_refresh_nibble_driver");
    $finish;
  end

  function automatic void emit_byte(logic [7:0] b, logic rs, logic [13:0] low_wait,
                                    logic last_low);
    xfer_q.push_back('{rs, b[7:4], lcdrn_pkg::WaitHigh, 1'b0});
    xfer_q.push_back('{rs, b[3:0], low_wait, last_low});
  endfunction

  function automatic void compute_nibbles(lcd_req_t rq);
    logic [7:0] ch;
    logic       r;
    r = cur_row;
    case (rq.kind)
      lcdrn_pkg::REQ_LOAD: begin
        if (int'(rq.col) < lcdrn_pkg::CharsPerLineDef) text_mem[rq.row][rq.col] = rq.chr;
      end
      lcdrn_pkg::REQ_REFRESH: begin
        ch = text_mem[r][cur_col];
        if (ch == 8'h00) ch = lcdrn_pkg::BlankChar;
        if (int'(cur_col) == lcdrn_pkg::CharsPerLineDef - 1) begin
          emit_byte(ch, 1'b1, lcdrn_pkg::WaitLow, 1'b0);
          emit_byte((r == 1'b0) ? lcdrn_pkg::AddrLine1Cmd : lcdrn_pkg::AddrLine0Cmd,
                    1'b0, lcdrn_pkg::WaitLow, 1'b1);
          cur_col = 4'd0;
          cur_row = ~r;
        end else begin
          emit_byte(ch, 1'b1, lcdrn_pkg::WaitLow, 1'b1);
          cur_col = cur_col + 4'd1;
        end
      end
      lcdrn_pkg::REQ_INIT: begin
        for (int i = 0; i < lcdrn_pkg::InitByteCount; i++) begin
          emit_byte(SetupSeq[i], 1'b0,
                    (i == 0) ? lcdrn_pkg::WaitFirst : lcdrn_pkg::WaitLow,
                    i == lcdrn_pkg::InitByteCount - 1);
        end
      end
      default: emit_byte(lcdrn_pkg::ClearCmd, 1'b0, lcdrn_pkg::WaitLow, 1'b1);
    endcase
  endfunction

  task automatic send_req(lcd_req_t rq);
    int base;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    req_type_i  <= rq.kind;
    row_i       <= rq.row;
    column_i    <= rq.col;
    char_code_i <= rq.chr;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    base = xfer_q.size();
    compute_nibbles(rq);
    if (rq.typed) begin
      while (xfer_q.size() > base) void'(xfer_q.pop_back());
      emit_byte(rq.t_byte, rq.t_rs, lcdrn_pkg::WaitLow, 1'b1);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random();
    lcd_req_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    rq.kind = (pick < 45) ? lcdrn_pkg::REQ_LOAD : (pick < 85) ? lcdrn_pkg::REQ_REFRESH :
              (pick < 93) ? lcdrn_pkg::REQ_CLEAR : lcdrn_pkg::REQ_INIT;
    rq.row = 1'($urandom_range(0, 1));
    rq.col = 4'($urandom_range(0, 15));
    rq.chr = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    rq.typed = 1'b0;
    rq.t_rs = 1'b0;
    rq.t_byte = 8'h00;
    send_req(rq);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (xfer_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left = HoldCycles;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    xfer_t e;
    if (rst_ni && pop && !empty) begin
      if (xfer_q.size() == 0) begin
        $error("unexpected transfer: rs=%0d nibble=%h wait=%0d last=%0d",
               reg_select_o, nibble_o, wait_us_o, last_o);
        errors++;
      end else begin
        e = xfer_q.pop_front();
        if (reg_select_o !== e.rs) begin
          $error("reg_select: expected %0d, got %0d", e.rs, reg_select_o);
          errors++;
        end
        if (nibble_o !== e.nib) begin
          $error("nibble: expected %h, got %h", e.nib, nibble_o);
          errors++;
        end
        if (wait_us_o !== e.wait_us) begin
          $error("wait_us: expected %0d, got %0d", e.wait_us, wait_us_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < lcdrn_pkg::CharsPerLineDef; c++) text_mem[r][c] = 8'h00;
    cur_row = 1'b0;
    cur_col = 4'd0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirCount; i++) send_req(DirTab[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 24 : 0;
      if (ph == 2) hold_start = 1'b1;
      repeat (RandPerPhase) send_random();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && xfer_q.size() == 0) begin
      $display("PASS char_lcd_refresh_nibble_driver");
    end else begin
      $display("FAIL char_lcd_refresh_nibble_driver");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/lcdrn_pkg.sv
design/lcdrn_front.sv
design/lcdrn_cmd_fifo.sv
design/lcdrn_back.sv
design/char_lcd_refresh_nibble_driver.sv
tb/sv/char_lcd_refresh_nibble_driver_tb.sv
